### src/adg_pkg.sv
// Shared constants and types of the adadelta gradient scaler.
`default_nettype none
package adg_pkg;

    localparam int VECTOR_DEPTH = 1024;
    localparam int IDX_W = (VECTOR_DEPTH > 1) ? $clog2(VECTOR_DEPTH) : 1;

    localparam int SQRT_STAGES = 32;
    localparam int DIV_STAGES  = 32;

    // Configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EPS   = 1'd1;

    localparam logic [15:0] DECAY_RESET = 16'd62259;
    localparam logic [31:0] EPS_RESET   = 32'd4295;

    // Command codes
    localparam logic CMD_LOAD   = 1'b0;
    localparam logic CMD_SMOOTH = 1'b1;

    // Side data that travels with an element through the square roots
    typedef struct packed {
        logic        neg;
        logic        last;
        logic [31:0] gm;
    } adg_sq_tag_t;

    // Side data that travels with an element through the divider
    typedef struct packed {
        logic neg;
        logic last;
        logic zero;
        logic sat;
    } adg_dv_tag_t;

endpackage
`default_nettype wire

### src/adg_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module adg_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                                        clk,
    input  wire logic                                        wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]                            wr_data,
    input  wire logic                                        rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic      [WIDTH-1:0]                            rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule
`default_nettype wire

### src/adg_update.sv
// Element index, state memories with forwarding, squares and running-average blend.
`default_nettype none
module adg_update (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       en,
    input  wire logic                       accept,
    input  wire logic                       cmd,
    input  wire logic signed [31:0]         param_value,
    input  wire logic signed [31:0]         grad_value,
    input  wire logic                       last_element,
    input  wire logic [15:0]                decay,
    output logic                            vld_out,
    output adg_pkg::adg_sq_tag_t            tag_out,
    output logic [63:0]                     avg_g,
    output logic [63:0]                     avg_d
);

    localparam logic [adg_pkg::IDX_W-1:0] IDX_LAST =
        adg_pkg::IDX_W'(adg_pkg::VECTOR_DEPTH - 1);

    function automatic logic [63:0] blend(input logic [63:0] avg, input logic [63:0] sq,
                                          input logic [15:0] rho);
        logic [16:0] inv;
        logic [48:0] lo;
        logic [48:0] hi;
        logic [63:0] r;
        inv = 17'h10000 - {1'b0, rho};
        lo  = ({17'h0, avg[31:0]} * {33'h0, rho}) + ({17'h0, sq[31:0]} * {32'h0, inv});
        hi  = ({17'h0, avg[63:32]} * {33'h0, rho}) + ({17'h0, sq[63:32]} * {32'h0, inv});
        if (hi[48])
        begin
            r = '1;
        end
        else
        begin
            r = {hi[47:0], 16'h0} + {31'h0, lo[48:16]};
        end
        return r;
    endfunction

    // element index
    logic [adg_pkg::IDX_W-1:0] elem_idx_reg;
    logic [adg_pkg::IDX_W-1:0] elem_idx_next;

    always_comb
    begin
        elem_idx_next = elem_idx_reg;
        if (accept)
        begin
            if (last_element || elem_idx_reg == IDX_LAST)
            begin
                elem_idx_next = '0;
            end
            else
            begin
                elem_idx_next = elem_idx_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            elem_idx_reg <= '0;
        end
        else
        begin
            elem_idx_reg <= elem_idx_next;
        end
    end

    // stage 1: previous parameter read
    logic                      v1_reg;
    logic                      cmd1_reg;
    logic signed [31:0]        p1_reg;
    logic signed [31:0]        g1_reg;
    logic                      last1_reg;
    logic [adg_pkg::IDX_W-1:0] idx1_reg;
    logic [31:0]               prev_rd;

    // stage 2: squares
    logic                      v2_reg;
    logic                      cmd2_reg;
    logic signed [31:0]        p2_reg;
    logic                      last2_reg;
    logic [adg_pkg::IDX_W-1:0] idx2_reg;
    logic [31:0]               gm2_reg;
    logic [31:0]               dm2_reg;
    logic                      neg2_reg;

    // stage 3: blend
    logic                      v3_reg;
    logic                      cmd3_reg;
    logic                      last3_reg;
    logic [adg_pkg::IDX_W-1:0] idx3_reg;
    logic [31:0]               gm3_reg;
    logic                      neg3_reg;
    logic [63:0]               sqg3_reg;
    logic [63:0]               sqd3_reg;
    logic [127:0]              avg_rd;

    // stage 4: results, also the newest average write
    logic                      v4_reg;
    logic                      cmd4_reg;
    logic                      last4_reg;
    logic [adg_pkg::IDX_W-1:0] idx4_reg;
    logic [31:0]               gm4_reg;
    logic                      neg4_reg;
    logic [63:0]               avg_g4_reg;
    logic [63:0]               avg_d4_reg;

    adg_ram #(
        .WIDTH (32),
        .DEPTH (adg_pkg::VECTOR_DEPTH)
    ) u_prev_ram (
        .clk     (clk),
        .wr_en   (en && v1_reg),
        .wr_addr (idx1_reg),
        .wr_data (p1_reg),
        .rd_en   (accept),
        .rd_addr (elem_idx_reg),
        .rd_data (prev_rd)
    );

    // stage 1 logic: forward the parameter of the element one stage ahead
    logic [31:0]        prev_fwd;
    logic signed [32:0] diff;
    logic [31:0]        dsat;
    logic [31:0]        dmag;
    logic [31:0]        gmag;

    always_comb
    begin
        prev_fwd = (v2_reg && idx2_reg == idx1_reg) ? p2_reg : prev_rd;
        diff     = {p1_reg[31], p1_reg} - {prev_fwd[31], prev_fwd};
        if (diff[32] != diff[31])
        begin
            dsat = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end
        else
        begin
            dsat = diff[31:0];
        end
        dmag = dsat[31] ? (32'h0 - dsat) : dsat;
        gmag = g1_reg[31] ? (32'h0 - g1_reg) : g1_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= accept;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd1_reg  <= cmd;
            p1_reg    <= param_value;
            g1_reg    <= grad_value;
            last1_reg <= last_element;
            idx1_reg  <= elem_idx_reg;

            cmd2_reg  <= cmd1_reg;
            p2_reg    <= p1_reg;
            last2_reg <= last1_reg;
            idx2_reg  <= idx1_reg;
            gm2_reg   <= gmag;
            dm2_reg   <= dmag;
            neg2_reg  <= g1_reg[31];

            cmd3_reg  <= cmd2_reg;
            last3_reg <= last2_reg;
            idx3_reg  <= idx2_reg;
            gm3_reg   <= gm2_reg;
            neg3_reg  <= neg2_reg;
            sqg3_reg  <= {32'h0, gm2_reg} * {32'h0, gm2_reg};
            sqd3_reg  <= {32'h0, dm2_reg} * {32'h0, dm2_reg};
        end
    end

    // stage 3 logic: forward the newest average write, held in stage 4
    logic [127:0] avg_old;
    logic [63:0]  avg_g_new;
    logic [63:0]  avg_d_new;

    always_comb
    begin
        avg_old = (v4_reg && idx4_reg == idx3_reg) ? {avg_g4_reg, avg_d4_reg} : avg_rd;
        if (cmd3_reg == adg_pkg::CMD_SMOOTH)
        begin
            avg_g_new = blend(avg_old[127:64], sqg3_reg, decay);
            avg_d_new = blend(avg_old[63:0], sqd3_reg, decay);
        end
        else
        begin
            avg_g_new = '0;
            avg_d_new = '0;
        end
    end

    adg_ram #(
        .WIDTH (128),
        .DEPTH (adg_pkg::VECTOR_DEPTH)
    ) u_avg_ram (
        .clk     (clk),
        .wr_en   (en && v3_reg),
        .wr_addr (idx3_reg),
        .wr_data ({avg_g_new, avg_d_new}),
        .rd_en   (en),
        .rd_addr (idx2_reg),
        .rd_data (avg_rd)
    );

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cmd4_reg   <= cmd3_reg;
            last4_reg  <= last3_reg;
            idx4_reg   <= idx3_reg;
            gm4_reg    <= gm3_reg;
            neg4_reg   <= neg3_reg;
            avg_g4_reg <= avg_g_new;
            avg_d4_reg <= avg_d_new;
        end
    end

    assign vld_out      = v4_reg && (cmd4_reg == adg_pkg::CMD_SMOOTH);
    assign tag_out.neg  = neg4_reg;
    assign tag_out.last = last4_reg;
    assign tag_out.gm   = gm4_reg;
    assign avg_g        = avg_g4_reg;
    assign avg_d        = avg_d4_reg;

    a_idx_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        accept && last_element |=> elem_idx_reg == '0)
        else $error("element index did not return to zero after last element");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        accept && !last_element && elem_idx_reg != IDX_LAST
        |=> elem_idx_reg == $past(elem_idx_reg) + 1'b1)
        else $error("element index did not advance by one");

endmodule
`default_nettype wire

### src/adg_sqrt_pipe.sv
// Two-lane pipelined integer square root, one root bit per stage.
`default_nettype none
module adg_sqrt_pipe (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vld_in,
    input  wire adg_pkg::adg_sq_tag_t tag_in,
    input  wire logic [63:0]          rad_g,
    input  wire logic [63:0]          rad_d,
    output logic                      vld_out,
    output adg_pkg::adg_sq_tag_t      tag_out,
    output logic [31:0]               root_g,
    output logic [31:0]               root_d
);

    typedef struct packed {
        logic [33:0] rem;
        logic [31:0] root;
        logic [63:0] rad;
    } sq_lane_t;

    function automatic sq_lane_t sq_step(input sq_lane_t a);
        logic [34:0] t;
        logic [34:0] trial;
        sq_lane_t    r;
        t     = {a.rem[32:0], a.rad[63:62]};
        trial = {1'b0, a.root, 2'b01};
        r.rad = {a.rad[61:0], 2'b00};
        if (t >= trial)
        begin
            r.rem  = 34'(t - trial);
            r.root = {a.root[30:0], 1'b1};
        end
        else
        begin
            r.rem  = t[33:0];
            r.root = {a.root[30:0], 1'b0};
        end
        return r;
    endfunction

    logic                 vld_reg  [adg_pkg::SQRT_STAGES];
    adg_pkg::adg_sq_tag_t tag_reg  [adg_pkg::SQRT_STAGES];
    sq_lane_t             lane_g_reg [adg_pkg::SQRT_STAGES];
    sq_lane_t             lane_d_reg [adg_pkg::SQRT_STAGES];

    for (genvar k = 0; k < adg_pkg::SQRT_STAGES; k++)
    begin : g_stage
        logic                 v_in;
        adg_pkg::adg_sq_tag_t t_in;
        sq_lane_t             g_in;
        sq_lane_t             d_in;

        if (k == 0)
        begin : g_first
            assign v_in = vld_in;
            assign t_in = tag_in;
            assign g_in = '{rem: '0, root: '0, rad: rad_g};
            assign d_in = '{rem: '0, root: '0, rad: rad_d};
        end
        else
        begin : g_next
            assign v_in = vld_reg[k-1];
            assign t_in = tag_reg[k-1];
            assign g_in = lane_g_reg[k-1];
            assign d_in = lane_d_reg[k-1];
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k]    <= t_in;
                lane_g_reg[k] <= sq_step(g_in);
                lane_d_reg[k] <= sq_step(d_in);
            end
        end
    end

    assign vld_out = vld_reg[adg_pkg::SQRT_STAGES-1];
    assign tag_out = tag_reg[adg_pkg::SQRT_STAGES-1];
    assign root_g  = lane_g_reg[adg_pkg::SQRT_STAGES-1].root;
    assign root_d  = lane_d_reg[adg_pkg::SQRT_STAGES-1].root;

endmodule
`default_nettype wire

### src/adg_div_pipe.sv
// Scale product and pipelined restoring divider, one quotient bit per stage.
`default_nettype none
module adg_div_pipe (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 en,
    input  wire logic                 vld_in,
    input  wire adg_pkg::adg_sq_tag_t tag_in,
    input  wire logic [31:0]          root_g,
    input  wire logic [31:0]          root_d,
    input  wire logic [31:0]          eps,
    output logic                      vld_out,
    output adg_pkg::adg_dv_tag_t      tag_out,
    output logic [31:0]               quot
);

    localparam int DIV_CNT = adg_pkg::DIV_STAGES + 1;

    typedef struct packed {
        logic [48:0] rem;
        logic [31:0] q;
        logic [31:0] plow;
        logic [48:0] den;
    } dv_lane_t;

    function automatic dv_lane_t dv_step(input dv_lane_t a);
        logic [49:0] t;
        dv_lane_t    r;
        t      = {a.rem, a.plow[31]};
        r.plow = {a.plow[30:0], 1'b0};
        r.den  = a.den;
        if (t >= {1'b0, a.den})
        begin
            r.rem = 49'(t - {1'b0, a.den});
            r.q   = {a.q[30:0], 1'b1};
        end
        else
        begin
            r.rem = t[48:0];
            r.q   = {a.q[30:0], 1'b0};
        end
        return r;
    endfunction

    // stage A: partial products of gradient times numerator, denominator sum
    logic                 va_reg;
    adg_pkg::adg_sq_tag_t ta_reg;
    logic [63:0]          pa_reg;
    logic [63:0]          pb_reg;
    logic [48:0]          dena_reg;

    // stage B: full product
    logic                 vb_reg;
    adg_pkg::adg_sq_tag_t tb_reg;
    logic [80:0]          prod_reg;
    logic [48:0]          denb_reg;

    // stage C and the divider steps
    logic                 vld_reg  [DIV_CNT];
    adg_pkg::adg_dv_tag_t tag_reg  [DIV_CNT];
    dv_lane_t             lane_reg [DIV_CNT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg <= 1'b0;
            vb_reg <= 1'b0;
        end
        else if (en)
        begin
            va_reg <= vld_in;
            vb_reg <= va_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ta_reg   <= tag_in;
            pa_reg   <= {32'h0, tag_in.gm} * {32'h0, root_d};
            pb_reg   <= {32'h0, tag_in.gm} * {32'h0, eps};
            dena_reg <= {1'b0, root_g, 16'h0} + {17'h0, eps};

            tb_reg   <= ta_reg;
            prod_reg <= {1'b0, pa_reg, 16'h0} + {17'h0, pb_reg};
            denb_reg <= dena_reg;
        end
    end

    for (genvar k = 0; k < DIV_CNT; k++)
    begin : g_stage
        logic                 v_in;
        adg_pkg::adg_dv_tag_t t_in;
        dv_lane_t             l_next;

        if (k == 0)
        begin : g_first
            assign v_in       = vb_reg;
            assign t_in.neg   = tb_reg.neg;
            assign t_in.last  = tb_reg.last;
            assign t_in.zero  = (denb_reg == '0);
            assign t_in.sat   = (prod_reg[80:32] >= denb_reg);
            assign l_next     = '{rem: prod_reg[80:32], q: '0, plow: prod_reg[31:0],
                                  den: denb_reg};
        end
        else
        begin : g_next
            assign v_in   = vld_reg[k-1];
            assign t_in   = tag_reg[k-1];
            assign l_next = dv_step(lane_reg[k-1]);
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else if (en)
            begin
                vld_reg[k] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                tag_reg[k]  <= t_in;
                lane_reg[k] <= l_next;
            end
        end
    end

    assign vld_out = vld_reg[DIV_CNT-1];
    assign tag_out = tag_reg[DIV_CNT-1];
    assign quot    = lane_reg[DIV_CNT-1].q;

endmodule
`default_nettype wire

### src/adadelta_gradient_scaler.sv
// Top level of the adadelta gradient scaler: config registers, pipeline and result register.
//
// Usage:
//   Stream parameter vectors one element per beat on the input channel
//   (in_valid/in_ready). cmd = load stores param_value as the previous value
//   of the current element and clears its two running averages; it makes no
//   result beat. cmd = smooth updates both averages and yields one result
//   beat on the output channel (out_valid/out_ready) carrying the scaled
//   gradient and a copy of the last flag. The element index advances on
//   every input beat and returns to zero after a beat flagged last.
//   Configuration (decay, epsilon) is written through cfg_wr_en/cfg_index/
//   cfg_data, by the user only while no element is in flight (not enforced).
// Timing:
//   A smooth element's result passes through 4 stages of state update,
//   32 square-root stages, 2 product stages, 33 divider stages and the
//   output register. One element enters per cycle while the pipeline does not hold.
// Reset and stall:
//   Reset empties the pipeline, zeroes the element index and loads the
//   default decay and epsilon; state memories hold garbage until loaded.
//   When the result register holds a beat that is not taken, the whole
//   pipeline and in_ready hold; nothing is dropped or repeated.
`default_nettype none
module adadelta_gradient_scaler (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic signed [31:0]            param_value,
    input  wire logic signed [31:0]            grad_value,
    input  wire logic                          last_element,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [31:0]                 grad_out,
    output logic                               last_out,
    input  wire logic                          cfg_wr_en,
    input  wire logic [adg_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [31:0]                   cfg_data
);

    localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [31:0] SAT_NEG = 32'h8000_0000;

    // configuration registers
    logic [15:0] decay_reg;
    logic [31:0] eps_reg;

    // result register
    logic        out_valid_reg;
    logic [31:0] grad_out_reg;
    logic        last_out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            decay_reg <= adg_pkg::DECAY_RESET;
            eps_reg   <= adg_pkg::EPS_RESET;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                adg_pkg::CFG_DECAY: decay_reg <= cfg_data[15:0];
                adg_pkg::CFG_EPS:   eps_reg   <= cfg_data;
                default:            ;
            endcase
        end
    end

    // advance the whole pipeline unless a result waits untaken
    logic adv;
    logic accept;

    assign adv      = !out_valid_reg || out_ready;
    assign in_ready = adv;
    assign accept   = in_valid && adv;

    // state update
    logic                 up_vld;
    adg_pkg::adg_sq_tag_t up_tag;
    logic [63:0]          up_avg_g;
    logic [63:0]          up_avg_d;

    adg_update u_update (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (adv),
        .accept       (accept),
        .cmd          (cmd),
        .param_value  (param_value),
        .grad_value   (grad_value),
        .last_element (last_element),
        .decay        (decay_reg),
        .vld_out      (up_vld),
        .tag_out      (up_tag),
        .avg_g        (up_avg_g),
        .avg_d        (up_avg_d)
    );

    // square roots of both averages
    logic                 sq_vld;
    adg_pkg::adg_sq_tag_t sq_tag;
    logic [31:0]          root_g;
    logic [31:0]          root_d;

    adg_sqrt_pipe u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (up_vld),
        .tag_in  (up_tag),
        .rad_g   (up_avg_g),
        .rad_d   (up_avg_d),
        .vld_out (sq_vld),
        .tag_out (sq_tag),
        .root_g  (root_g),
        .root_d  (root_d)
    );

    // gradient times numerator over denominator
    logic                 dv_vld;
    adg_pkg::adg_dv_tag_t dv_tag;
    logic [31:0]          quot;

    adg_div_pipe u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (adv),
        .vld_in  (sq_vld),
        .tag_in  (sq_tag),
        .root_g  (root_g),
        .root_d  (root_d),
        .eps     (eps_reg),
        .vld_out (dv_vld),
        .tag_out (dv_tag),
        .quot    (quot)
    );

    // sign, saturation and zero-denominator handling
    logic [31:0] res;

    always_comb
    begin
        if (dv_tag.zero)
        begin
            res = '0;
        end
        else if (dv_tag.neg)
        begin
            res = (dv_tag.sat || quot > SAT_NEG) ? SAT_NEG : (32'h0 - quot);
        end
        else
        begin
            res = (dv_tag.sat || quot[31]) ? SAT_POS : quot;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= dv_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            grad_out_reg <= res;
            last_out_reg <= dv_tag.last;
        end
    end

    assign out_valid = out_valid_reg;
    assign grad_out  = grad_out_reg;
    assign last_out  = last_out_reg;

    a_zero_den: assert property (@(posedge clk) disable iff (!rst_n)
        adv && dv_vld && dv_tag.zero |=> grad_out == '0)
        else $error("zero denominator did not give a zero result");

    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        adv && dv_vld && !dv_tag.neg && !dv_tag.zero |=> !grad_out[31])
        else $error("positive gradient gave a negative result");

    a_neg_sign: assert property (@(posedge clk) disable iff (!rst_n)
        adv && dv_vld && dv_tag.neg && !dv_tag.zero |=> grad_out[31] || grad_out == '0)
        else $error("negative gradient gave a positive result");

endmodule
`default_nettype wire
